@@ design/adaptive_ma_position_trader_defines.svh @@
// Assertion macros used by the adaptive average trader top level.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ADAPTIVE_MA_POSITION_TRADER_DEFINES_SVH
`define ADAPTIVE_MA_POSITION_TRADER_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define AMAPT_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define AMAPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/amapt_pkg.sv @@
// Shared types and constants of the adaptive average trader.
// No dependencies; used by the divider and the top level.
`default_nettype none

package amapt_pkg;

    localparam int PRICE_W     = 32;
    localparam int BAL_W       = 48;
    localparam int AVG_W       = 33;
    localparam int SF_W        = 18;
    localparam int FACTOR_BITS = 16;
    localparam int DIV_DW      = 48;
    localparam int DIV_SW      = 44;

    localparam logic [1:0] ACT_HOLD = 2'd0;
    localparam logic [1:0] ACT_BUY  = 2'd1;
    localparam logic [1:0] ACT_SELL = 2'd2;

    localparam logic [2:0] REG_WINDOW = 3'd0;
    localparam logic [2:0] REG_LIMIT  = 3'd1;
    localparam logic [2:0] REG_PCT    = 3'd2;
    localparam logic [2:0] REG_HOLD   = 3'd3;
    localparam logic [2:0] REG_GAIN   = 3'd4;
    localparam logic [2:0] REG_SLOW   = 3'd5;

    localparam logic signed [SF_W-1:0] SF_RESET = 18'sd32768;

    typedef struct packed {
        logic [PRICE_W-1:0] close_price;
        logic               in_period;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [7:0]       position;
        logic signed [BAL_W-1:0] balance;
        logic signed [BAL_W-1:0] settled_balance;
        logic [AVG_W-1:0]        average_level;
        logic                    history_short;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_SW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ design/amapt_stream_if.sv @@
// Valid/ready stream channel carrying one payload item per transfer.
// Payload type is a parameter; the trader uses the types of amapt_pkg.
`default_nettype none

interface amapt_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/adaptive_ma_position_trader.sv @@
// Adaptive moving-average position trader, top level.
// Depends on amapt_pkg, amapt_stream_if, amapt_ram, amapt_div and the defines header.
//
//  channel   dir   payload                                  transfer when
//  i_in      in    close_price, in_period                   valid & ready
//  o_out     out   action, position, balance, settled,      valid & ready
//                  average_level, history_short
//  apb       in    window .. slow_constant registers        psel & penable & pwrite
//
// A history item leaves the sequencer idle with input ready high. A trading day holds
// input ready low from its transfer until it returns, walking the price ring one entry
// per cycle, one per window change, then check, efficiency ratio division, target,
// smoothing target division (both on the shared one-bit-per-cycle divider), multiply,
// factor, multiply, average, band, decision, settle and output. Without the divisions
// (first day or zero change sum) check leads to band. The memories need no clearing
// pass after reset. A result waits in the output register while the next item is
// taken; a day whose result finds that register full holds until it drains.
`default_nettype none
`include "adaptive_ma_position_trader_defines.svh"

module adaptive_ma_position_trader #(
    parameter int WINDOW_MAX   = 64,
    parameter int POSITION_MAX = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    amapt_stream_if.sink     i_in,
    amapt_stream_if.source   o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import amapt_pkg::*;

    localparam int RING_DEPTH = WINDOW_MAX + 1;
    localparam int RAW  = $clog2(RING_DEPTH);
    localparam int HCW  = $clog2(RING_DEPTH + 1);
    localparam int NW   = $clog2(WINDOW_MAX + 1);
    localparam int SUMW = PRICE_W + NW;
    localparam int QD   = POSITION_MAX;
    localparam int QAW  = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW  = $clog2(QD + 1);
    localparam int HW   = $clog2(POSITION_MAX + 1) + 1;
    localparam int SETW = ((HW + AVG_W > BAL_W) ? HW + AVG_W : BAL_W) + 1;

    localparam logic signed [21:0] SF_HI  = 22'sd131071;
    localparam logic signed [21:0] SF_LO  = -22'sd131072;
    localparam logic signed [37:0] AVG_HI = 38'sh1_FFFF_FFFF;
    localparam logic signed [SETW-1:0] BAL_HI = SETW'(48'sh7FFF_FFFF_FFFF);
    localparam logic signed [SETW-1:0] BAL_LO = -BAL_HI - SETW'(1);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_SUM    = 14'b00000000000010,
        S_CHECK  = 14'b00000000000100,
        S_DIV1   = 14'b00000000001000,
        S_T      = 14'b00000000010000,
        S_DIV2   = 14'b00000000100000,
        S_MUL1   = 14'b00000001000000,
        S_SF     = 14'b00000010000000,
        S_MUL2   = 14'b00000100000000,
        S_AVG    = 14'b00001000000000,
        S_BAND   = 14'b00010000000000,
        S_DEC    = 14'b00100000000000,
        S_SETTLE = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } t_state;

    function automatic logic signed [BAL_W-1:0] sat_bal(input logic signed [SETW-1:0] v);
        if (v > BAL_HI) begin
            return BAL_HI[BAL_W-1:0];
        end else if (v < BAL_LO) begin
            return BAL_LO[BAL_W-1:0];
        end
        return v[BAL_W-1:0];
    endfunction

    function automatic logic [PRICE_W-1:0] absdiff(input logic [PRICE_W-1:0] a,
                                                   input logic [PRICE_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    t_state r_state, n_state;

    // configuration
    logic [6:0]  r_cfg_wlen, r_cfg_limit, r_cfg_pct;
    logic [15:0] r_cfg_hold;
    logic [16:0] r_cfg_gain;
    logic [17:0] r_cfg_slow;

    // control state
    logic [RAW-1:0]  r_ring_wr;
    logic [HCW-1:0]  r_hist;
    logic            r_first_pend;
    logic [31:0]     r_day;
    logic [QAW-1:0]  r_q_head;
    logic [QCW-1:0]  r_q_count;
    logic signed [HW-1:0]    r_held;
    logic signed [BAL_W-1:0] r_cash;
    logic signed [SF_W-1:0]  r_sf;
    logic [NW-1:0]   r_cnt;
    logic            r_pend;
    logic            r_out_valid;

    // per-day datapath
    logic [PRICE_W-1:0] r_close, r_prev;
    logic [NW-1:0]      r_m;
    logic               r_short;
    logic [RAW-1:0]     r_rd_addr;
    logic [SUMW-1:0]    r_sum;
    logic [AVG_W-1:0]   r_avg;
    logic [16:0]        r_er;
    logic               r_tneg;
    logic signed [SF_W-1:0] r_t;
    logic signed [36:0] r_prod1;
    logic signed [52:0] r_prod2;
    logic [38:0]        r_c100;
    logic [40:0]        r_buy_rhs;
    logic signed [41:0] r_sell_lhs;
    logic [1:0]         r_action;
    logic signed [HW+AVG_W-1:0] r_sprod;
    t_out_item          r_out;

    logic [PRICE_W-1:0] w_ring_rdata, w_q_rdata;
    logic               w_in_acc, w_day_acc, w_cfg_wr, w_out_free;
    logic [2:0]         w_idx;
    logic [NW-1:0]      w_n, w_m;
    logic [RAW-1:0]     w_ring_dec, w_rd_dec;
    logic               w_issue;
    logic               w_go_div;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;

    logic [17:0]        w_a;
    logic [18:0]        w_b, w_den, w_mag;
    logic signed [19:0] w_num;
    logic signed [18:0] w_tdiff;
    logic signed [21:0] w_sf_sum;
    logic signed [34:0] w_adiff;
    logic signed [37:0] w_avg_sum;
    logic signed [7:0]  w_plo;

    logic signed [HW-1:0] w_lim;
    logic [32:0]        w_age;
    logic               w_due, w_nbuy, w_nsell, w_fbuy, w_fsell;
    logic               w_sell, w_buy, w_repl;
    logic [QAW:0]       w_q_sum;
    logic [QAW-1:0]     w_q_waddr, w_q_head_inc;
    logic               w_q_we;
    logic               w_q_match;
    logic signed [SETW-1:0] w_cash_add, w_cash_sub, w_set_sum;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_idx    = paddr[4:2];
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_wlen  <= 7'd1;
            r_cfg_limit <= 7'd0;
            r_cfg_pct   <= 7'd0;
            r_cfg_hold  <= 16'd1;
            r_cfg_gain  <= 17'd0;
            r_cfg_slow  <= 18'd0;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_WINDOW: r_cfg_wlen  <= pwdata[6:0];
                REG_LIMIT:  r_cfg_limit <= pwdata[6:0];
                REG_PCT:    r_cfg_pct   <= pwdata[6:0];
                REG_HOLD:   r_cfg_hold  <= pwdata[15:0];
                REG_GAIN:   r_cfg_gain  <= pwdata[16:0];
                REG_SLOW:   r_cfg_slow  <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_WINDOW: prdata = 32'(r_cfg_wlen);
            REG_LIMIT:  prdata = 32'(r_cfg_limit);
            REG_PCT:    prdata = 32'(r_cfg_pct);
            REG_HOLD:   prdata = 32'(r_cfg_hold);
            REG_GAIN:   prdata = 32'(r_cfg_gain);
            REG_SLOW:   prdata = 32'(r_cfg_slow);
            default:    prdata = '0;
        endcase
    end

    // ---------------- memories and divider ----------------
    amapt_ram #(.WIDTH(PRICE_W), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (r_ring_wr),
        .i_wdata (i_in.data.close_price),
        .i_raddr (r_rd_addr),
        .o_rdata (w_ring_rdata)
    );

    amapt_ram #(.WIDTH(32), .DEPTH(QD)) u_queue (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (r_day),
        .i_raddr (r_q_head),
        .o_rdata (w_q_rdata)
    );

    amapt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ---------------- combinational helpers ----------------
    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_day_acc  = w_in_acc && i_in.data.in_period;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign w_n = (32'(r_cfg_wlen) > WINDOW_MAX) ? NW'(WINDOW_MAX) : NW'(r_cfg_wlen);
    assign w_m = (32'(r_hist) < 32'(w_n)) ? NW'(r_hist) : w_n;
    assign w_ring_dec = (r_ring_wr == '0) ? RAW'(RING_DEPTH - 1) : (r_ring_wr - 1'b1);
    assign w_rd_dec   = (r_rd_addr == '0) ? RAW'(RING_DEPTH - 1) : (r_rd_addr - 1'b1);
    assign w_issue    = (r_state == S_SUM) && (r_cnt < r_m);
    assign w_go_div   = (r_sum != '0) && !r_first_pend;

    // smoothing target operands
    assign w_a   = {r_er, 1'b0};
    assign w_b   = 19'd65536 + 19'(r_cfg_slow);
    assign w_num = $signed(20'(w_a)) - $signed(20'(w_b));
    assign w_den = 19'(w_a) + w_b;
    assign w_mag = w_num[19] ? 19'(-w_num) : 19'(w_num);

    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = {w_mag, 16'b0, 13'b0} >> 13;
        w_div_req.divisor  = DIV_SW'(w_den);
        if (r_state == S_CHECK) begin
            w_div_req.start    = w_go_div;
            w_div_req.dividend = DIV_DW'({absdiff(r_close, r_prev), 16'b0});
            w_div_req.divisor  = DIV_SW'(r_sum);
        end else if (r_state == S_T) begin
            w_div_req.start = 1'b1;
        end
    end

    assign w_tdiff  = $signed({r_t[SF_W-1], r_t}) - $signed({r_sf[SF_W-1], r_sf});
    assign w_sf_sum = 22'(r_sf) + 22'(r_prod1 >>> FACTOR_BITS);
    assign w_adiff  = $signed({3'b0, r_close}) - $signed({2'b0, r_avg});
    assign w_avg_sum = $signed({5'b0, r_avg}) + 38'(r_prod2 >>> FACTOR_BITS);
    assign w_plo    = 8'sd100 - $signed({1'b0, r_cfg_pct});

    // decision
    assign w_lim  = (32'(r_cfg_limit) > POSITION_MAX) ? HW'(POSITION_MAX) : HW'(r_cfg_limit);
    assign w_nbuy = (r_sum != '0) && (41'(r_c100) >= r_buy_rhs) && (r_held < w_lim);
    assign w_nsell = (r_sum != '0) && !w_nbuy && (r_sell_lhs >= $signed({3'b0, r_c100}))
                     && (r_held > -w_lim);
    assign w_age  = {1'b0, r_day - w_q_rdata} + 33'd1;
    assign w_due  = (r_q_count != '0) && (w_age >= 33'(r_cfg_hold));
    assign w_fsell = w_due && (r_held > 0);
    assign w_fbuy  = w_due && (r_held < 0);
    assign w_sell = (w_nsell && !w_fbuy) || (!w_nbuy && !w_nsell && w_fsell);
    assign w_buy  = (w_nbuy && !w_fsell) || (!w_nbuy && !w_nsell && w_fbuy);
    assign w_repl = (w_nbuy || w_nsell) && (w_fbuy || w_fsell) && !w_sell && !w_buy;

    assign w_q_sum      = {1'b0, r_q_head} + (QAW + 1)'(r_q_count);
    assign w_q_waddr    = (32'(w_q_sum) >= QD) ? QAW'(w_q_sum - (QAW + 1)'(QD))
                                               : QAW'(w_q_sum);
    assign w_q_head_inc = (32'(r_q_head) == QD - 1) ? '0 : (r_q_head + 1'b1);
    // push on opening a position or on replacing the oldest open day
    assign w_q_we = (r_state == S_DEC) &&
                    ((w_sell && (r_held <= 0)) || (w_buy && (r_held >= 0)) || w_repl);
    assign w_q_match = (r_held >= 0) ? (32'(r_q_count) == 32'(r_held))
                                     : (32'(r_q_count) == 32'(-r_held));

    assign w_cash_add = SETW'(r_cash) + $signed(SETW'({1'b0, r_close}));
    assign w_cash_sub = SETW'(r_cash) - $signed(SETW'({1'b0, r_close}));
    assign w_set_sum  = SETW'(r_cash) + SETW'(r_sprod);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_day_acc) n_state = S_SUM;
            S_SUM:    if ((r_cnt == r_m) && !r_pend) n_state = S_CHECK;
            S_CHECK:  n_state = w_go_div ? S_DIV1 : S_BAND;
            S_DIV1:   if (w_div_rsp.done) n_state = S_T;
            S_T:      n_state = S_DIV2;
            S_DIV2:   if (w_div_rsp.done) n_state = S_MUL1;
            S_MUL1:   n_state = S_SF;
            S_SF:     n_state = S_MUL2;
            S_MUL2:   n_state = S_AVG;
            S_AVG:    n_state = S_BAND;
            S_BAND:   n_state = S_DEC;
            S_DEC:    n_state = S_SETTLE;
            S_SETTLE: n_state = S_OUT;
            S_OUT:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ring_wr    <= '0;
            r_hist       <= '0;
            r_first_pend <= 1'b1;
            r_day        <= '0;
            r_q_head     <= '0;
            r_q_count    <= '0;
            r_held       <= '0;
            r_cash       <= '0;
            r_sf         <= SF_RESET;
            r_cnt        <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc) begin
                r_ring_wr <= (32'(r_ring_wr) == RING_DEPTH - 1) ? '0 : (r_ring_wr + 1'b1);
                if (32'(r_hist) < RING_DEPTH) begin
                    r_hist <= r_hist + 1'b1;
                end
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end
            if (r_state == S_SUM) begin
                r_pend <= w_issue;
                if (w_issue) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (r_state == S_CHECK) begin
                r_first_pend <= 1'b0;
            end
            if (r_state == S_SF) begin
                if (w_sf_sum > SF_HI) begin
                    r_sf <= SF_HI[SF_W-1:0];
                end else if (w_sf_sum < SF_LO) begin
                    r_sf <= SF_LO[SF_W-1:0];
                end else begin
                    r_sf <= w_sf_sum[SF_W-1:0];
                end
            end
            if (r_state == S_DEC) begin
                r_day <= r_day + 1'b1;
                if (w_sell) begin
                    r_held <= r_held - 1'b1;
                    r_cash <= sat_bal(w_cash_add);
                    if (r_held > 0) begin
                        r_q_head  <= w_q_head_inc;
                        r_q_count <= r_q_count - 1'b1;
                    end else begin
                        r_q_count <= r_q_count + 1'b1;
                    end
                end else if (w_buy) begin
                    r_held <= r_held + 1'b1;
                    r_cash <= sat_bal(w_cash_sub);
                    if (r_held < 0) begin
                        r_q_head  <= w_q_head_inc;
                        r_q_count <= r_q_count - 1'b1;
                    end else begin
                        r_q_count <= r_q_count + 1'b1;
                    end
                end else if (w_repl) begin
                    r_q_head <= w_q_head_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_close   <= i_in.data.close_price;
            r_prev    <= i_in.data.close_price;
            r_m       <= w_m;
            r_short   <= 32'(r_hist) < 32'(w_n) + 1;
            r_rd_addr <= w_ring_dec;
            r_sum     <= '0;
        end
        if (w_issue) begin
            r_rd_addr <= w_rd_dec;
        end
        // accumulate one change per returned ring entry
        if ((r_state == S_SUM) && r_pend) begin
            r_sum  <= r_sum + SUMW'(absdiff(r_prev, w_ring_rdata));
            r_prev <= w_ring_rdata;
        end
        if ((r_state == S_CHECK) && r_first_pend) begin
            r_avg <= {1'b0, r_close};
        end
        if ((r_state == S_DIV1) && w_div_rsp.done) begin
            r_er <= w_div_rsp.quotient[16:0];
        end
        if (r_state == S_T) begin
            r_tneg <= w_num[19];
        end
        if ((r_state == S_DIV2) && w_div_rsp.done) begin
            r_t <= r_tneg ? -$signed({1'b0, w_div_rsp.quotient[16:0]})
                          : $signed({1'b0, w_div_rsp.quotient[16:0]});
        end
        if (r_state == S_MUL1) begin
            r_prod1 <= $signed({1'b0, r_cfg_gain}) * w_tdiff;
        end
        if (r_state == S_MUL2) begin
            r_prod2 <= r_sf * w_adiff;
        end
        if (r_state == S_AVG) begin
            if (w_avg_sum < 0) begin
                r_avg <= '0;
            end else if (w_avg_sum > AVG_HI) begin
                r_avg <= AVG_HI[AVG_W-1:0];
            end else begin
                r_avg <= w_avg_sum[AVG_W-1:0];
            end
        end
        if (r_state == S_BAND) begin
            r_c100     <= 39'(r_close) * 39'd100;
            r_buy_rhs  <= 41'(r_avg) * 41'(8'd100 + 8'(r_cfg_pct));
            r_sell_lhs <= $signed({1'b0, r_avg}) * w_plo;
        end
        if (r_state == S_DEC) begin
            r_action <= w_sell ? ACT_SELL : (w_buy ? ACT_BUY : ACT_HOLD);
        end
        if (r_state == S_SETTLE) begin
            r_sprod <= r_held * $signed({1'b0, r_close});
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_out.action          <= r_action;
            r_out.position        <= 8'(r_held);
            r_out.balance         <= r_cash;
            r_out.settled_balance <= sat_bal(w_set_sum);
            r_out.average_level   <= r_avg;
            r_out.history_short   <= r_short;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `AMAPT_ASSERT_ALWAYS(a_queue_tracks_units, w_q_match, "queue count differs from held units")
    `AMAPT_ASSERT_ALWAYS(a_hist_bound, 32'(r_hist) <= RING_DEPTH, "history count passed ring depth")
    `AMAPT_ASSERT_NEXT(a_busy_after_day, w_day_acc, !i_in.ready, "ready high after a day transfer")
endmodule

`default_nettype wire

@@ design/amapt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module amapt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                    i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                    o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

@@ design/amapt_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Uses request and response types of amapt_pkg.
`default_nettype none

module amapt_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire amapt_pkg::t_div_req i_req,
    output amapt_pkg::t_div_rsp      o_rsp
);
    import amapt_pkg::*;

    localparam int CW = $clog2(DIV_DW);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIV_SW:0]   r_rem;
    logic [DIV_DW-1:0] r_quo;
    logic [DIV_SW-1:0] r_div;

    logic [DIV_SW:0]   w_trial;
    logic              w_ge;
    logic [DIV_SW:0]   w_rem_n;

    assign w_trial = {r_rem[DIV_SW-1:0], r_quo[DIV_DW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_rem_n = w_ge ? (w_trial - {1'b0, r_div}) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(DIV_DW - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_rem_n;
            r_quo <= {r_quo[DIV_DW-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

`default_nettype wire
